/* src/sweh_pkg.sv */
`default_nettype none

package sweh_pkg;

    localparam int unsigned STAMP_W   = 48;
    localparam int unsigned WSEC_W    = 31;
    localparam int unsigned OUTCNT_W  = 7;
    localparam int unsigned USPS_W    = 20;
    localparam int unsigned WIN_US_W  = WSEC_W + USPS_W;
    localparam int unsigned THR_W     = WIN_US_W + 1;

    localparam logic [USPS_W-1:0] US_PER_SEC = USPS_W'(1000000);

    typedef enum logic [1:0] {
        OP_RECORD     = 2'd0,
        OP_EXPIRE     = 2'd1,
        OP_REC_EXPIRE = 2'd2,
        OP_COUNT      = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_THR,
        ST_REC,
        ST_TRIM,
        ST_LOOKUP,
        ST_EXP,
        ST_CNT
    } t_state;

    typedef struct packed {
        logic [1:0]         operation;
        logic [STAMP_W-1:0] now_boottime_us;
        logic [STAMP_W-1:0] now_monotonic_us;
        logic [WSEC_W-1:0]  window_seconds;
        logic               clock_select;
    } t_in_word;

    typedef struct packed {
        logic [OUTCNT_W-1:0] events_in_window;
        logic [OUTCNT_W-1:0] events_held;
    } t_out_word;

    typedef struct packed {
        logic mul_en;
        logic thr_en;
    } t_wcmp_ctl;

endpackage

`default_nettype wire

/* src/sliding_window_event_history.sv */
`default_nettype none

// Channel   Dir  Handshake                    Word
// command   in   start, busy                  i_in  (t_in_word)
// result    out  o_res_strobe (one cycle)     o_res (t_out_word)
// config    in   i_cfg_valid, o_cfg_ready     i_cfg_data (max_events)
//
// Record: REC then TRIM, with one further TRIM step per entry trimmed by max_events.
// Expire / count: MUL, THR, LOOKUP, then one EXP or CNT step, with one ring read, per entry
// examined (up to HISTORY_DEPTH); record-and-expire runs REC and TRIM between THR and LOOKUP.
// Reset clears the oldest pointer, count and max_events; scan pointer and stamp memory are not cleared.
// busy is high from the accepting edge until the result strobe; the result
// cannot be stalled and a new start may be taken in the strobe cycle.
// o_cfg_ready is low while busy.
module sliding_window_event_history
    import sweh_pkg::*;
#(
    parameter int HISTORY_DEPTH = 64
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  start,
    output logic                 busy,
    input  wire  t_in_word       i_in,
    output logic                 o_res_strobe,
    output t_out_word            o_res,
    input  wire                  i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire  [OUTCNT_W-1:0]  i_cfg_data
);

    localparam int IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
    localparam int CMP_W = (CNT_W > OUTCNT_W) ? CNT_W : OUTCNT_W;
    localparam int SUM_W = IDX_W + 1;
    localparam int WORD_W = 2 * STAMP_W;

    t_state               r_state, n_state;
    t_in_word             r_in;
    logic [IDX_W-1:0]     r_oldest, n_oldest;
    logic [CNT_W-1:0]     r_count, n_count;
    logic [IDX_W-1:0]     r_scan, n_scan;
    logic [CNT_W-1:0]     r_left, n_left;
    logic [OUTCNT_W-1:0]  r_max_events;
    logic                 r_res_stb, n_res_stb;
    t_out_word            r_res, n_res;

    logic [WORD_W-1:0]    r_mem [HISTORY_DEPTH];
    logic [WORD_W-1:0]    r_rd_data;
    logic [IDX_W-1:0]     rd_addr;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;

    t_wcmp_ctl            wcmp_ctl;
    logic [STAMP_W-1:0]   now_sel;
    logic [STAMP_W-1:0]   stamp_sel;
    logic                 stamp_gt, stamp_ge;
    logic [SUM_W-1:0]     app_sum;
    logic [IDX_W-1:0]     app_pos;
    t_op                  op;

    function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] p);
        return (p == IDX_W'(HISTORY_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign op          = t_op'(r_in.operation);
    assign busy        = (r_state != ST_IDLE);
    assign o_cfg_ready = !busy;
    assign o_res_strobe = r_res_stb;
    assign o_res       = r_res;

    // word layout: {mono, boot}
    assign now_sel   = r_in.clock_select ? r_in.now_monotonic_us : r_in.now_boottime_us;
    assign stamp_sel = r_in.clock_select ? r_rd_data[WORD_W-1:STAMP_W]
                                         : r_rd_data[STAMP_W-1:0];

    assign app_sum = SUM_W'(r_oldest) + SUM_W'(r_count);
    assign app_pos = (app_sum >= SUM_W'(HISTORY_DEPTH))
                   ? IDX_W'(app_sum - SUM_W'(HISTORY_DEPTH)) : IDX_W'(app_sum);

    sweh_window_cmp u_wcmp (
        .i_clk            (i_clk),
        .i_ctl            (wcmp_ctl),
        .i_window_seconds (r_in.window_seconds),
        .i_now_us         (now_sel),
        .i_stamp_us       (stamp_sel),
        .o_stamp_gt       (stamp_gt),
        .o_stamp_ge       (stamp_ge)
    );

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= {r_in.now_monotonic_us, r_in.now_boottime_us};
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_oldest     <= '0;
            r_count      <= '0;
            r_max_events <= '0;
            r_res_stb    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_oldest  <= n_oldest;
            r_count   <= n_count;
            r_res_stb <= n_res_stb;
            if (i_cfg_valid && o_cfg_ready) begin
                r_max_events <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_in <= i_in;
        end
        r_scan <= n_scan;
        r_left <= n_left;
        r_res  <= n_res;
    end

    always_comb begin
        logic finish;
        logic [OUTCNT_W-1:0] win_cnt;

        n_state   = r_state;
        n_oldest  = r_oldest;
        n_count   = r_count;
        n_scan    = r_scan;
        n_left    = r_left;
        n_res_stb = 1'b0;
        n_res     = r_res;
        rd_addr   = r_scan;
        wr_en     = 1'b0;
        wr_addr   = app_pos;
        wcmp_ctl  = '0;
        finish    = 1'b0;
        win_cnt   = '0;

        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = (t_op'(i_in.operation) == OP_RECORD) ? ST_REC : ST_MUL;
                end
            end
            ST_MUL: begin
                wcmp_ctl.mul_en = 1'b1;
                n_state = ST_THR;
            end
            ST_THR: begin
                wcmp_ctl.thr_en = 1'b1;
                n_state = (op == OP_REC_EXPIRE) ? ST_REC : ST_LOOKUP;
            end
            ST_REC: begin
                wr_en = 1'b1;
                if (r_count == CNT_W'(HISTORY_DEPTH)) begin
                    // full ring: newest overwrites the oldest slot
                    wr_addr  = r_oldest;
                    n_oldest = ring_next(r_oldest);
                end else begin
                    n_count = r_count + 1'b1;
                end
                n_state = ST_TRIM;
            end
            ST_TRIM: begin
                if ((r_max_events != '0) &&
                    (CMP_W'(r_count) > CMP_W'(r_max_events))) begin
                    n_oldest = ring_next(r_oldest);
                    n_count  = r_count - 1'b1;
                end else if (op == OP_REC_EXPIRE) begin
                    n_state = ST_LOOKUP;
                end else begin
                    finish = 1'b1;
                end
            end
            ST_LOOKUP: begin
                rd_addr = r_oldest;
                n_scan  = ring_next(r_oldest);
                n_left  = r_count;
                if (r_count == '0) begin
                    finish = 1'b1;
                end else begin
                    n_state = (op == OP_COUNT) ? ST_CNT : ST_EXP;
                end
            end
            ST_EXP: begin
                if (stamp_gt) begin
                    finish = 1'b1;
                end else begin
                    n_oldest = ring_next(r_oldest);
                    n_count  = r_count - 1'b1;
                    rd_addr  = ring_next(r_oldest);
                    if (r_count == CNT_W'(1)) begin
                        finish = 1'b1;
                    end
                end
            end
            ST_CNT: begin
                if (stamp_ge) begin
                    win_cnt = OUTCNT_W'(r_left);
                    finish  = 1'b1;
                end else if (r_left == CNT_W'(1)) begin
                    finish = 1'b1;
                end else begin
                    rd_addr = r_scan;
                    n_scan  = ring_next(r_scan);
                    n_left  = r_left - 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (finish) begin
            n_state                = ST_IDLE;
            n_res_stb              = 1'b1;
            n_res.events_in_window = win_cnt;
            n_res.events_held      = OUTCNT_W'(n_count);
        end
    end

endmodule

`default_nettype wire

/* src/sweh_window_cmp.sv */
`default_nettype none

// Window length in us, then threshold = now - window, then one stamp compare
// per cycle against the held threshold.
module sweh_window_cmp
    import sweh_pkg::*;
(
    input  wire                      i_clk,
    input  wire  t_wcmp_ctl          i_ctl,
    input  wire  [WSEC_W-1:0]        i_window_seconds,
    input  wire  [STAMP_W-1:0]       i_now_us,
    input  wire  [STAMP_W-1:0]       i_stamp_us,
    output logic                     o_stamp_gt,
    output logic                     o_stamp_ge
);

    logic        [WIN_US_W-1:0] r_window_us;
    logic signed [THR_W-1:0]    r_thr;
    logic signed [THR_W-1:0]    stamp_s;

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_window_us <= WIN_US_W'(i_window_seconds) * WIN_US_W'(US_PER_SEC);
        end
        if (i_ctl.thr_en) begin
            r_thr <= $signed({(THR_W - STAMP_W)'(0), i_now_us})
                   - $signed({1'b0, r_window_us});
        end
    end

    // elapsed < window  <=>  stamp > thr ; elapsed <= window  <=>  stamp >= thr
    assign stamp_s    = $signed({(THR_W - STAMP_W)'(0), i_stamp_us});
    assign o_stamp_gt = (stamp_s > r_thr);
    assign o_stamp_ge = (stamp_s >= r_thr);

endmodule

`default_nettype wire
